@@ src/bqn_pkg.sv @@
// Shared constants, types and helpers for the boolean query normalizer.
`timescale 1ns / 1ps
`default_nettype none

package bqn_pkg;

  localparam int unsigned MaxNestingDefault = 255;
  localparam int unsigned QueueDepth        = 4;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChBar   = 8'h7C;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChUpO   = 8'h4F;
  localparam logic [7:0] ChUpR   = 8'h52;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpN   = 8'h4E;
  localparam logic [7:0] ChUpD   = 8'h44;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic {
    JOB_DECIDE,
    JOB_CLOSE
  } job_kind_e;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_OP,
    CMD_STATUS
  } cmd_mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BRACKET  = 2'd1,
    ST_OPERATOR = 2'd2
  } status_e;

  // nx[0] is the next character, nx_vld marks positions before the query end
  typedef struct packed {
    job_kind_e       kind;
    logic [7:0]      ch;
    logic [2:0][7:0] nx;
    logic [2:0]      nx_vld;
    logic            brk_err;
  } job_t;

  function automatic logic is_space(input logic [7:0] c);
    logic r;
    r = c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/bqn_if.sv @@
// Valid/ready channel interfaces for query characters and normalized results.
`timescale 1ns / 1ps
`default_nettype none

interface bqn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] query_char;
  logic       end_of_query;

  modport source (output valid, query_char, end_of_query, input ready);
  modport sink   (input valid, query_char, end_of_query, output ready);
endinterface

interface bqn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_valid;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, out_char, out_valid, out_last, status, input ready);
  modport sink   (input valid, out_char, out_valid, out_last, status, output ready);
endinterface

`default_nettype wire

@@ src/bqn_front.sv @@
// Front end: arrival checks, lookahead window and decide-job generation.
`timescale 1ns / 1ps
`default_nettype none

module bqn_front #(
  parameter int unsigned MaxNesting = bqn_pkg::MaxNestingDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bqn_in_if.sink        in_i,
  output bqn_pkg::job_t job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);
  import bqn_pkg::*;

  localparam int unsigned DepthW = $clog2(MaxNesting + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MaxNesting);

  logic [7:0]        win_q [3];
  logic [7:0]        win_d [3];
  logic [7:0]        dbuf_q [4];
  logic [7:0]        dbuf_d [4];
  logic [1:0]        fill_q, fill_d;
  logic              quote_q, quote_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              brk_q, brk_d;
  logic              drain_q, drain_d;
  logic [2:0]        dcnt_q, dcnt_d;
  logic              dbrk_q, dbrk_d;

  logic              acc;
  logic [7:0]        ca;
  logic              quote_n;
  logic [DepthW-1:0] depth_n;
  logic              aerr;

  assign in_i.ready = !drain_q && job_ready_i;
  assign acc        = in_i.valid && in_i.ready;

  // arrival-side classification
  always_comb begin
    ca      = in_i.query_char;
    quote_n = quote_q;
    depth_n = depth_q;
    aerr    = 1'b0;
    if (in_i.query_char == ChQuote) begin
      quote_n = !quote_q;
    end else if (!quote_q) begin
      if (in_i.query_char == ChLpar) begin
        if (depth_q >= DepthMax) begin
          aerr = 1'b1;
        end else begin
          depth_n = depth_q + DepthW'(1);
        end
      end else if (in_i.query_char == ChRpar) begin
        if (depth_q == '0) begin
          aerr = 1'b1;
        end else begin
          depth_n = depth_q - DepthW'(1);
        end
      end else if (is_space(in_i.query_char)) begin
        ca = ChSpace;
      end
    end
  end

  always_comb begin
    job_o         = '0;
    job_o.kind    = JOB_DECIDE;
    job_valid_o   = 1'b0;
    if (drain_q) begin
      job_valid_o = 1'b1;
      if (dcnt_q != 3'd0) begin
        job_o.ch        = dbuf_q[0];
        job_o.nx[0]     = dbuf_q[1];
        job_o.nx[1]     = dbuf_q[2];
        job_o.nx[2]     = dbuf_q[3];
        job_o.nx_vld[0] = dcnt_q > 3'd1;
        job_o.nx_vld[1] = dcnt_q > 3'd2;
        job_o.nx_vld[2] = dcnt_q > 3'd3;
      end else begin
        job_o.kind    = JOB_CLOSE;
        job_o.brk_err = dbrk_q;
      end
    end else begin
      job_valid_o  = acc && !in_i.end_of_query && (fill_q == 2'd3);
      job_o.ch     = win_q[0];
      job_o.nx[0]  = win_q[1];
      job_o.nx[1]  = win_q[2];
      job_o.nx[2]  = ca;
      job_o.nx_vld = 3'b111;
    end
  end

  always_comb begin
    win_d   = win_q;
    dbuf_d  = dbuf_q;
    fill_d  = fill_q;
    quote_d = quote_q;
    depth_d = depth_q;
    brk_d   = brk_q;
    drain_d = drain_q;
    dcnt_d  = dcnt_q;
    dbrk_d  = dbrk_q;
    if (drain_q && job_ready_i) begin
      if (dcnt_q != 3'd0) begin
        dbuf_d[0] = dbuf_q[1];
        dbuf_d[1] = dbuf_q[2];
        dbuf_d[2] = dbuf_q[3];
        dcnt_d    = dcnt_q - 3'd1;
      end else begin
        drain_d = 1'b0;
      end
    end
    if (acc) begin
      if (!in_i.end_of_query) begin
        if (fill_q == 2'd3) begin
          win_d[0] = win_q[1];
          win_d[1] = win_q[2];
          win_d[2] = ca;
        end else begin
          win_d[fill_q] = ca;
          fill_d        = fill_q + 2'd1;
        end
        quote_d = quote_n;
        depth_d = depth_n;
        brk_d   = brk_q | aerr;
      end else begin
        dbuf_d[0]      = win_q[0];
        dbuf_d[1]      = win_q[1];
        dbuf_d[2]      = win_q[2];
        dbuf_d[fill_q] = ca;
        dcnt_d         = {1'b0, fill_q} + 3'd1;
        drain_d        = 1'b1;
        dbrk_d         = brk_q | aerr | quote_n | (depth_n != '0);
        fill_d         = 2'd0;
        quote_d        = 1'b0;
        depth_d        = '0;
        brk_d          = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= 2'd0;
      quote_q <= 1'b0;
      depth_q <= '0;
      brk_q   <= 1'b0;
      drain_q <= 1'b0;
      dcnt_q  <= 3'd0;
      dbrk_q  <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      quote_q <= quote_d;
      depth_q <= depth_d;
      brk_q   <= brk_d;
      drain_q <= drain_d;
      dcnt_q  <= dcnt_d;
      dbrk_q  <= dbrk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    dbuf_q <= dbuf_d;
  end

`ifndef ASSERT_OFF
  a_drain_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> !in_i.ready)
    else $error("input taken during end-of-query drain");

  a_last_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.end_of_query |=> drain_q && dcnt_q != 3'd0)
    else $error("end of query did not start a drain");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !in_i.end_of_query && fill_q != 2'd3 |=> fill_q == $past(fill_q) + 2'd1)
    else $error("window fill did not advance");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthMax)
    else $error("bracket depth beyond limit");
`endif

endmodule

`default_nettype wire

@@ src/bqn_fifo.sv @@
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module bqn_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bqn_pkg::job_t data_i,
  output logic          ready_o,
  input  logic          pop_i,
  output bqn_pkg::job_t data_o,
  output logic          valid_o
);
  import bqn_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign ready_o = cnt_q != (PtrW + 1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PtrW + 1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW + 1)'(QueueDepth))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

@@ src/bqn_back.sv @@
// Back end: operator rewriting, phrase tracking and result emission.
`timescale 1ns / 1ps
`default_nettype none

module bqn_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bqn_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_pop_o,
  bqn_out_if.source     out_o
);
  import bqn_pkg::*;

  logic [1:0] skip_q, skip_d;
  logic       phrase_q, phrase_d;
  logic       prev_op_q, prev_op_d;
  logic       op_err_q, op_err_d;

  logic       cmd_vld_q, cmd_vld_d;
  cmd_mode_e  cmd_mode_q, cmd_mode_d;
  logic [7:0] cmd_ch_q, cmd_ch_d;
  status_e    cmd_st_q, cmd_st_d;
  logic [1:0] step_q, step_d;

  logic       out_vld_q, out_vld_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_fv_q, out_fv_d;
  logic       out_last_q, out_last_d;
  logic [1:0] out_st_q, out_st_d;

  logic       out_free, emit, cmd_done, take, pop;
  logic       new_vld;
  cmd_mode_e  new_mode;
  logic [7:0] new_ch;
  status_e    new_st;
  logic       is_bar, same1, run3, or_op, and_op;

  assign out_free = !out_vld_q || out_o.ready;
  assign emit     = cmd_vld_q && out_free;
  assign cmd_done = emit && ((cmd_mode_q != CMD_OP) || (step_q == 2'd2));
  assign take     = !cmd_vld_q || cmd_done;
  assign pop      = take && job_valid_i;
  assign job_pop_o = pop;

  assign is_bar = (job_i.ch == ChBar) || (job_i.ch == ChAmp);
  assign same1  = job_i.nx_vld[0] && (job_i.nx[0] == job_i.ch);
  assign run3   = same1 && job_i.nx_vld[1] && (job_i.nx[1] == job_i.ch);
  assign or_op  = (job_i.ch == ChUpO) && job_i.nx_vld[0] && (job_i.nx[0] == ChUpR)
                  && job_i.nx_vld[1] && (job_i.nx[1] == ChSpace);
  assign and_op = (job_i.ch == ChUpA) && job_i.nx_vld[0] && (job_i.nx[0] == ChUpN)
                  && job_i.nx_vld[1] && (job_i.nx[1] == ChUpD)
                  && job_i.nx_vld[2] && (job_i.nx[2] == ChSpace);

  // decide on the queue head
  always_comb begin
    skip_d    = skip_q;
    phrase_d  = phrase_q;
    prev_op_d = prev_op_q;
    op_err_d  = op_err_q;
    new_vld   = 1'b0;
    new_mode  = CMD_CHAR;
    new_ch    = job_i.ch;
    new_st    = ST_OK;
    if (pop) begin
      if (job_i.kind == JOB_CLOSE) begin
        new_vld  = 1'b1;
        new_mode = CMD_STATUS;
        if (job_i.brk_err) begin
          new_st = ST_BRACKET;
        end else if (op_err_q || prev_op_q) begin
          new_st = ST_OPERATOR;
        end
        skip_d    = 2'd0;
        phrase_d  = 1'b0;
        prev_op_d = 1'b1;
        op_err_d  = 1'b0;
      end else if (skip_q != 2'd0) begin
        skip_d = skip_q - 2'd1;
      end else if (job_i.ch == ChQuote) begin
        phrase_d  = !phrase_q;
        prev_op_d = 1'b0;
        new_vld   = 1'b1;
      end else if (phrase_q) begin
        new_vld = 1'b1;
      end else if (is_bar && !run3) begin
        if (prev_op_q || !job_i.nx_vld[0]) begin
          op_err_d = 1'b1;
        end
        prev_op_d = 1'b1;
        new_vld   = 1'b1;
        new_mode  = CMD_OP;
        if (same1) begin
          skip_d = 2'd1;
        end
      end else if (or_op) begin
        if (prev_op_q) begin
          op_err_d = 1'b1;
        end
        prev_op_d = 1'b1;
        new_vld   = 1'b1;
        new_mode  = CMD_OP;
        new_ch    = ChBar;
        skip_d    = 2'd2;
      end else if (and_op) begin
        if (prev_op_q) begin
          op_err_d = 1'b1;
        end
        prev_op_d = 1'b1;
        new_vld   = 1'b1;
        new_mode  = CMD_OP;
        new_ch    = ChAmp;
        skip_d    = 2'd3;
      end else begin
        new_vld = 1'b1;
        if (job_i.ch != ChSpace) begin
          prev_op_d = 1'b0;
        end
      end
    end
  end

  // command sequencer
  always_comb begin
    cmd_vld_d  = cmd_vld_q;
    cmd_mode_d = cmd_mode_q;
    cmd_ch_d   = cmd_ch_q;
    cmd_st_d   = cmd_st_q;
    step_d     = step_q;
    if (take) begin
      cmd_vld_d  = pop && new_vld;
      cmd_mode_d = new_mode;
      cmd_ch_d   = new_ch;
      cmd_st_d   = new_st;
      step_d     = 2'd0;
    end else if (emit) begin
      step_d = step_q + 2'd1;
    end
  end

  // output register
  always_comb begin
    out_vld_d  = out_vld_q && !out_o.ready;
    out_char_d = out_char_q;
    out_fv_d   = out_fv_q;
    out_last_d = out_last_q;
    out_st_d   = out_st_q;
    if (emit) begin
      out_vld_d = 1'b1;
      case (cmd_mode_q)
        CMD_CHAR: begin
          out_char_d = cmd_ch_q;
          out_fv_d   = 1'b1;
          out_last_d = 1'b0;
          out_st_d   = ST_OK;
        end
        CMD_OP: begin
          out_char_d = (step_q == 2'd1) ? cmd_ch_q : ChSpace;
          out_fv_d   = 1'b1;
          out_last_d = 1'b0;
          out_st_d   = ST_OK;
        end
        CMD_STATUS: begin
          out_char_d = ChNul;
          out_fv_d   = 1'b0;
          out_last_d = 1'b1;
          out_st_d   = cmd_st_q;
        end
        default: begin
          out_char_d = ChNul;
          out_fv_d   = 1'b0;
          out_last_d = 1'b0;
          out_st_d   = ST_OK;
        end
      endcase
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_char  = out_char_q;
  assign out_o.out_valid = out_fv_q;
  assign out_o.out_last  = out_last_q;
  assign out_o.status    = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q     <= 2'd0;
      phrase_q   <= 1'b0;
      prev_op_q  <= 1'b1;
      op_err_q   <= 1'b0;
      cmd_vld_q  <= 1'b0;
      cmd_mode_q <= CMD_CHAR;
      step_q     <= 2'd0;
      out_vld_q  <= 1'b0;
    end else begin
      skip_q     <= skip_d;
      phrase_q   <= phrase_d;
      prev_op_q  <= prev_op_d;
      op_err_q   <= op_err_d;
      cmd_vld_q  <= cmd_vld_d;
      cmd_mode_q <= cmd_mode_d;
      step_q     <= step_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_ch_q   <= cmd_ch_d;
    cmd_st_q   <= cmd_st_d;
    out_char_q <= out_char_d;
    out_fv_q   <= out_fv_d;
    out_last_q <= out_last_d;
    out_st_q   <= out_st_d;
  end

`ifndef ASSERT_OFF
  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.out_last |-> out_o.status == ST_OK && out_o.out_valid)
    else $error("status on a non-final item");

  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_vld_q && cmd_mode_q != CMD_OP |-> step_q == 2'd0)
    else $error("multi-step sequence on a single item");

  a_op_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_vld_q |-> step_q != 2'd3)
    else $error("operator expansion overran");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && job_i.kind == JOB_CLOSE |=> skip_q == 2'd0 && prev_op_q && !op_err_q && !phrase_q)
    else $error("query state not cleared at close");
`endif

endmodule

`default_nettype wire

@@ src/boolean_query_normalizer_top.sv @@
// Top level of the boolean query normalizer.
`timescale 1ns / 1ps
`default_nettype none

// Streams a search query in, one character per item, and streams the
// normalized text out, one character per item, followed by one status-only
// item (out_last high) per query. Each character is decided once three more
// have arrived, so output lags input by three characters until end_of_query.
// The front end takes one item per cycle while the job queue has room and no
// flush is under way; the back end emits one result per cycle from a
// registered output while the consumer accepts, so a plain character gives
// one output item and an operator (|, &, OR, AND) gives three. At the end of
// a query the front end stops taking items while it flushes the lookahead
// window and the status item into the job queue, one job per pending character
// plus one for the status item (two to five jobs), and waits while it is full.

module boolean_query_normalizer_top #(
  parameter int unsigned MaxNesting = bqn_pkg::MaxNestingDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bqn_in_if.sink    in_i,
  bqn_out_if.source out_o
);
  import bqn_pkg::*;

  job_t fq_in, fq_out;
  logic fq_push, fq_ready, fq_pop, fq_valid;
  logic fq_wr;

  // a job enters the queue only when the queue can take it
  assign fq_wr = fq_push && fq_ready;

  bqn_front #(
    .MaxNesting (MaxNesting)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_o       (fq_in),
    .job_valid_o (fq_push),
    .job_ready_i (fq_ready)
  );

  bqn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_wr),
    .data_i  (fq_in),
    .ready_o (fq_ready),
    .pop_i   (fq_pop),
    .data_o  (fq_out),
    .valid_o (fq_valid)
  );

  bqn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (fq_out),
    .job_valid_i (fq_valid),
    .job_pop_o   (fq_pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
